>>> hw/rtl/dcc_service_mode_programmer_macros.svh
`ifndef DCC_SERVICE_MODE_PROGRAMMER_MACROS_SVH
`define DCC_SERVICE_MODE_PROGRAMMER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define DCCSMP_ASSERT_NOW(label, clk_i, rst_ni, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define DCCSMP_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dccsmp_pkg.sv
`default_nettype none

package dccsmp_pkg;

  localparam int unsigned CV_W    = 11;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [CV_W-1:0] CV_COUNT = 11'd1024;

  // item modes
  localparam logic [2:0] MODE_TICK       = 3'd0;
  localparam logic [2:0] MODE_WRITE_BYTE = 3'd1;
  localparam logic [2:0] MODE_WRITE_BIT  = 3'd2;
  localparam logic [2:0] MODE_READ_BYTE  = 3'd3;
  localparam logic [2:0] MODE_READ_BIT   = 3'd4;
  localparam logic [2:0] MODE_POWER_OFF  = 3'd5;

  // packet kinds
  localparam logic [2:0] KIND_RESET       = 3'd0;
  localparam logic [2:0] KIND_WRITE_BYTE  = 3'd1;
  localparam logic [2:0] KIND_WRITE_BIT   = 3'd2;
  localparam logic [2:0] KIND_VERIFY_BIT  = 3'd3;
  localparam logic [2:0] KIND_VERIFY_BYTE = 3'd4;

  // status codes
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_SUCCESS = 2'd2;
  localparam logic [1:0] ST_FAILED  = 2'd3;

  // jobs
  localparam logic [1:0] JOB_OFF   = 2'd0;
  localparam logic [1:0] JOB_WRITE = 2'd1;
  localparam logic [1:0] JOB_READ  = 2'd2;

  localparam logic [3:0] BIT_BYTE_VERIFY = 4'd8;
  localparam logic [3:0] BIT_NONE        = 4'd15;
  localparam logic [3:0] BIT_TOP         = 4'd7;

  // register indexes
  localparam logic [1:0] REG_ACK_INC   = 2'd0;
  localparam logic [1:0] REG_PREAMBLE  = 2'd1;
  localparam logic [1:0] REG_REPEATS   = 2'd2;
  localparam logic [1:0] REG_TRAILING  = 2'd3;

  localparam logic [15:0] RST_ACK_INC  = 16'd60;
  localparam logic [4:0]  RST_PREAMBLE = 5'd20;
  localparam logic [2:0]  RST_REPEATS  = 3'd5;
  localparam logic [2:0]  RST_TRAILING = 3'd5;

  typedef struct packed {
    logic [15:0] ack_inc;
    logic [4:0]  preamble;
    logic [2:0]  repeats;
    logic [2:0]  trailing;
  } cfg_t;

  typedef struct packed {
    logic            packet_valid;
    logic [2:0]      packet_kind;
    logic [CV_W-1:0] packet_cv;
    logic [2:0]      packet_bit;
    logic            packet_bit_value;
    logic [7:0]      packet_byte;
    logic [1:0]      status;
    logic [7:0]      read_value;
    logic            track_enabled;
  } res_t;

  // a zero count is taken as one
  function automatic logic [2:0] min1_3(input logic [2:0] v);
    min1_3 = (v == 3'd0) ? 3'd1 : v;
  endfunction

  function automatic logic [4:0] min1_5(input logic [4:0] v);
    min1_5 = (v == 5'd0) ? 5'd1 : v;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dccsmp_regs.sv
`default_nettype none

module dccsmp_regs
  import dccsmp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ack_inc  <= RST_ACK_INC;
      cfg_r.preamble <= RST_PREAMBLE;
      cfg_r.repeats  <= RST_REPEATS;
      cfg_r.trailing <= RST_TRAILING;
    end else if (wr_en) begin
      case (idx)
        REG_ACK_INC:  cfg_r.ack_inc  <= pwdata[15:0];
        REG_PREAMBLE: cfg_r.preamble <= pwdata[4:0];
        REG_REPEATS:  cfg_r.repeats  <= pwdata[2:0];
        REG_TRAILING: cfg_r.trailing <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ACK_INC:  prdata = {16'd0, cfg_r.ack_inc};
      REG_PREAMBLE: prdata = {27'd0, cfg_r.preamble};
      REG_REPEATS:  prdata = {29'd0, cfg_r.repeats};
      REG_TRAILING: prdata = {29'd0, cfg_r.trailing};
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/dcc_service_mode_programmer.sv
// Service-mode (direct) programming sequencer. Each input item is a start, a
// power-off or a tick; every accepted item yields exactly one result item,
// held in an output register. One item per clock is sustained: in_ready is
// high whenever the output register is empty or its item is being taken in
// the same cycle, and the sequencer state and result are updated in a single
// pass of logic at the acceptance edge. Registers sit on an APB-style port at
// byte addresses 0, 4, 8 and 12; the user must write them only while idle, as
// the block does not enforce it. No clearing pass is needed after reset.
`default_nettype none

`include "dcc_service_mode_programmer_macros.svh"

module dcc_service_mode_programmer
  import dccsmp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_mode,
  input  wire logic [CV_W-1:0]    in_cv_number,
  input  wire logic [2:0]         in_bit_number,
  input  wire logic               in_bit_value,
  input  wire logic [7:0]         in_byte_value,
  input  wire logic               in_need_packet,
  input  wire logic [15:0]        in_short_current,
  input  wire logic [15:0]        in_long_current,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_packet_valid,
  output logic [2:0]              out_packet_kind,
  output logic [CV_W-1:0]         out_packet_cv,
  output logic [2:0]              out_packet_bit,
  output logic                    out_packet_bit_value,
  output logic [7:0]              out_packet_byte,
  output logic [1:0]              out_status,
  output logic [7:0]              out_read_value,
  output logic                    out_track_enabled,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  cfg_t cfg;

  dccsmp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [1:0]      job_r, job_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [4:0]      pre_r, pre_nxt;
  logic [2:0]      wr_r, wr_nxt;
  logic [2:0]      bwr_r, bwr_nxt;
  logic [2:0]      trail_r, trail_nxt;
  logic [2:0]      ver_r, ver_nxt;
  logic [3:0]      cur_r, cur_nxt;
  logic            trial_r, trial_nxt;
  logic [3:0]      single_r, single_nxt;
  logic [7:0]      found_r, found_nxt;
  logic [16:0]     thr_r, thr_nxt;
  logic [CV_W-1:0] tcv_r, tcv_nxt;
  logic [2:0]      tbit_r, tbit_nxt;
  logic            tbv_r, tbv_nxt;
  logic [7:0]      tbyte_r, tbyte_nxt;

  logic            out_valid_r;
  res_t            res_r, res_nxt;
  logic            accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic        is_start;
    logic        ack;
    logic        single;
    logic [16:0] new_thr;

    job_nxt    = job_r;
    status_nxt = status_r;
    pre_nxt    = pre_r;
    wr_nxt     = wr_r;
    bwr_nxt    = bwr_r;
    trail_nxt  = trail_r;
    ver_nxt    = ver_r;
    cur_nxt    = cur_r;
    trial_nxt  = trial_r;
    single_nxt = single_r;
    found_nxt  = found_r;
    thr_nxt    = thr_r;
    tcv_nxt    = tcv_r;
    tbit_nxt   = tbit_r;
    tbv_nxt    = tbv_r;
    tbyte_nxt  = tbyte_r;
    res_nxt    = '0;

    is_start = (in_mode == MODE_WRITE_BYTE) || (in_mode == MODE_WRITE_BIT) ||
               (in_mode == MODE_READ_BYTE) || (in_mode == MODE_READ_BIT);
    single   = !single_r[3];
    new_thr  = {1'b0, in_long_current} + {1'b0, cfg.ack_inc};
    ack      = 1'b0;

    if (is_start) begin
      if (in_cv_number == '0 || in_cv_number > CV_COUNT) begin
        job_nxt    = JOB_OFF;
        status_nxt = ST_FAILED;
      end else begin
        job_nxt    = (in_mode == MODE_WRITE_BYTE || in_mode == MODE_WRITE_BIT) ?
                     JOB_WRITE : JOB_READ;
        status_nxt = ST_BUSY;
        tcv_nxt    = in_cv_number;
        tbit_nxt   = in_bit_number;
        tbv_nxt    = in_bit_value;
        tbyte_nxt  = in_byte_value;
        pre_nxt    = min1_5(cfg.preamble);
        wr_nxt     = (in_mode == MODE_WRITE_BYTE) ? min1_3(cfg.repeats) : 3'd0;
        bwr_nxt    = (in_mode == MODE_WRITE_BIT) ? min1_3(cfg.repeats) : 3'd0;
        trail_nxt  = (in_mode == MODE_WRITE_BYTE || in_mode == MODE_WRITE_BIT) ?
                     min1_3(cfg.trailing) : 3'd0;
        ver_nxt    = 3'd0;
        cur_nxt    = 4'd0;
        found_nxt  = 8'd0;
        single_nxt = (in_mode == MODE_READ_BIT) ? {1'b0, in_bit_number} : BIT_NONE;
        trial_nxt  = (in_mode != MODE_READ_BIT);
      end
    end else if (in_mode == MODE_POWER_OFF) begin
      if (status_r == ST_BUSY) status_nxt = ST_FAILED;
      job_nxt = JOB_OFF;
    end else if (job_r == JOB_WRITE) begin
      if (pre_r != 5'd0) begin
        if (in_need_packet) begin
          res_nxt.packet_valid = 1'b1;
          res_nxt.packet_kind  = KIND_RESET;
          pre_nxt = pre_r - 5'd1;
          if (pre_nxt == 5'd0) thr_nxt = new_thr;
        end
      end else begin
        ack = ({1'b0, in_short_current} >= thr_r);
        if (ack) begin
          wr_nxt     = 3'd0;
          bwr_nxt    = 3'd0;
          trail_nxt  = 3'd0;
          status_nxt = ST_SUCCESS;
        end
        if (wr_nxt != 3'd0) begin
          if (in_need_packet) begin
            res_nxt.packet_valid = 1'b1;
            res_nxt.packet_kind  = KIND_WRITE_BYTE;
            res_nxt.packet_cv    = tcv_r;
            res_nxt.packet_byte  = tbyte_r;
            wr_nxt = wr_nxt - 3'd1;
          end
        end else if (bwr_nxt != 3'd0) begin
          if (in_need_packet) begin
            res_nxt.packet_valid     = 1'b1;
            res_nxt.packet_kind      = KIND_WRITE_BIT;
            res_nxt.packet_cv        = tcv_r;
            res_nxt.packet_bit       = tbit_r;
            res_nxt.packet_bit_value = tbv_r;
            bwr_nxt = bwr_nxt - 3'd1;
          end
        end else if (trail_nxt != 3'd0) begin
          if (in_need_packet) begin
            res_nxt.packet_valid = 1'b1;
            res_nxt.packet_kind  = KIND_RESET;
            trail_nxt = trail_nxt - 3'd1;
          end
        end else begin
          if (status_nxt == ST_BUSY) status_nxt = ST_FAILED;
          job_nxt = JOB_OFF;
        end
      end
    end else if (job_r == JOB_READ) begin
      if (pre_r != 5'd0) begin
        if (in_need_packet) begin
          res_nxt.packet_valid = 1'b1;
          res_nxt.packet_kind  = KIND_RESET;
          pre_nxt = pre_r - 5'd1;
          if (pre_nxt == 5'd0) begin
            thr_nxt = new_thr;
            cur_nxt = single ? single_r : BIT_TOP;
            ver_nxt = min1_3(cfg.repeats);
          end
        end
      end else begin
        ack = ({1'b0, in_short_current} >= thr_r);
        if (ack) begin
          if (single) begin
            found_nxt  = {7'd0, trial_r};
            status_nxt = ST_SUCCESS;
            ver_nxt    = 3'd0;
            trail_nxt  = 3'd0;
          end else if (cur_r[3]) begin
            status_nxt = ST_SUCCESS;
            ver_nxt    = 3'd0;
            trail_nxt  = 3'd0;
          end else begin
            found_nxt = found_r | (8'd1 << cur_r[2:0]);
          end
        end
        if (ver_nxt != 3'd0) begin
          if (in_need_packet) begin
            res_nxt.packet_valid = 1'b1;
            res_nxt.packet_cv    = tcv_r;
            if (cur_r[3]) begin
              res_nxt.packet_kind = KIND_VERIFY_BYTE;
              res_nxt.packet_byte = found_nxt;
            end else begin
              res_nxt.packet_kind      = KIND_VERIFY_BIT;
              res_nxt.packet_bit       = cur_r[2:0];
              res_nxt.packet_bit_value = trial_r;
            end
            ver_nxt = ver_nxt - 3'd1;
            if (ver_nxt == 3'd0) trail_nxt = min1_3(cfg.trailing);
          end
        end else if (trail_nxt != 3'd0) begin
          if (in_need_packet) begin
            res_nxt.packet_valid = 1'b1;
            res_nxt.packet_kind  = KIND_RESET;
            trail_nxt = trail_nxt - 3'd1;
          end
          if (trail_nxt == 3'd0) thr_nxt = new_thr;
        end else if (single) begin
          if (!trial_r && status_nxt == ST_BUSY) begin
            trial_nxt = 1'b1;
            ver_nxt   = min1_3(cfg.repeats);
          end else begin
            if (status_nxt == ST_BUSY) status_nxt = ST_FAILED;
            job_nxt = JOB_OFF;
          end
        end else if (cur_r[3]) begin
          if (status_nxt == ST_BUSY) status_nxt = ST_FAILED;
          job_nxt = JOB_OFF;
        end else if (cur_r != 4'd0) begin
          cur_nxt   = cur_r - 4'd1;
          trial_nxt = 1'b1;
          ver_nxt   = min1_3(cfg.repeats);
        end else begin
          cur_nxt = BIT_BYTE_VERIFY;
          ver_nxt = min1_3(cfg.repeats);
        end
      end
    end

    res_nxt.status        = status_nxt;
    res_nxt.read_value    = found_nxt;
    res_nxt.track_enabled = (job_nxt != JOB_OFF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r       <= JOB_OFF;
      status_r    <= ST_IDLE;
      pre_r       <= 5'd0;
      wr_r        <= 3'd0;
      bwr_r       <= 3'd0;
      trail_r     <= 3'd0;
      ver_r       <= 3'd0;
      cur_r       <= 4'd0;
      trial_r     <= 1'b1;
      single_r    <= BIT_NONE;
      found_r     <= 8'd0;
      thr_r       <= 17'd0;
      tcv_r       <= 11'd1;
      tbit_r      <= 3'd0;
      tbv_r       <= 1'b0;
      tbyte_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else if (accept) begin
      job_r       <= job_nxt;
      status_r    <= status_nxt;
      pre_r       <= pre_nxt;
      wr_r        <= wr_nxt;
      bwr_r       <= bwr_nxt;
      trail_r     <= trail_nxt;
      ver_r       <= ver_nxt;
      cur_r       <= cur_nxt;
      trial_r     <= trial_nxt;
      single_r    <= single_nxt;
      found_r     <= found_nxt;
      thr_r       <= thr_nxt;
      tcv_r       <= tcv_nxt;
      tbit_r      <= tbit_nxt;
      tbv_r       <= tbv_nxt;
      tbyte_r     <= tbyte_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_packet_valid     = res_r.packet_valid;
  assign out_packet_kind      = res_r.packet_kind;
  assign out_packet_cv        = res_r.packet_cv;
  assign out_packet_bit       = res_r.packet_bit;
  assign out_packet_bit_value = res_r.packet_bit_value;
  assign out_packet_byte      = res_r.packet_byte;
  assign out_status           = res_r.status;
  assign out_read_value       = res_r.read_value;
  assign out_track_enabled    = res_r.track_enabled;

  // a running job is either busy or already acknowledged
  `DCCSMP_ASSERT_NOW(a_job_status, clk, rst_n, job_r != JOB_OFF,
    status_r == ST_BUSY || status_r == ST_SUCCESS, "running job with bad status")

  // a packet only goes out while the track is powered
  `DCCSMP_ASSERT_NOW(a_pkt_powered, clk, rst_n, out_valid_r && res_r.packet_valid,
    res_r.track_enabled, "packet sent with track off")

  // a good write-byte or read-bit start leaves a busy job behind
  `DCCSMP_ASSERT_NEXT(a_start_busy, clk, rst_n,
    accept && (in_mode == MODE_WRITE_BYTE || in_mode == MODE_READ_BIT) &&
    in_cv_number != '0 && in_cv_number <= CV_COUNT,
    status_r == ST_BUSY && job_r != JOB_OFF, "start did not begin a job")

endmodule

`default_nettype wire

>>> dv/dccsmp_sequence_checker.sv
module dccsmp_sequence_checker
  import dccsmp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic [CV_W-1:0]    in_cv_number,
  input  logic [2:0]         in_bit_number,
  input  logic               in_bit_value,
  input  logic [7:0]         in_byte_value,
  input  logic               in_need_packet,
  input  logic [15:0]        in_short_current,
  input  logic [15:0]        in_long_current,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_packet_valid,
  input  logic [2:0]         out_packet_kind,
  input  logic [CV_W-1:0]    out_packet_cv,
  input  logic [2:0]         out_packet_bit,
  input  logic               out_packet_bit_value,
  input  logic [7:0]         out_packet_byte,
  input  logic [1:0]         out_status,
  input  logic [7:0]         out_read_value,
  input  logic               out_track_enabled,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int unsigned        fault_count,
  output int unsigned        slots_pending,
  output bit                 job_running
);

  typedef struct packed {
    logic [2:0]      mode;
    logic [CV_W-1:0] cv;
    logic [2:0]      bitn;
    logic            bval;
    logic [7:0]      data;
    logic            need;
    logic [15:0]     short_cur;
    logic [15:0]     long_ma;
  } prog_item_t;

  logic [15:0] ack_inc;
  logic [4:0]  preamble_cfg;
  logic [2:0]  repeats_cfg;
  logic [2:0]  trailing_cfg;

  logic [1:0]      job;
  logic [1:0]      job_status;
  logic [4:0]      preamble_left;
  logic [2:0]      writes_left;
  logic [2:0]      bit_writes_left;
  logic [2:0]      trailing_left;
  logic [2:0]      verifies_left;
  logic [3:0]      current_bit;
  logic            trial;
  logic [3:0]      single_target;
  logic [7:0]      value_found;
  logic [16:0]     threshold;
  logic [CV_W-1:0] tgt_cv;
  logic [2:0]      tgt_bit;
  logic            tgt_bval;
  logic [7:0]      tgt_byte;

  res_t slots_due[$];

  function automatic logic [2:0] repeat_count(input logic [2:0] v);
    return (v == 3'd0) ? 3'd1 : v;
  endfunction

  function automatic res_t packet_slot(input logic [2:0] kind, input logic [CV_W-1:0] cv,
                                       input logic [2:0] bitn, input logic bval,
                                       input logic [7:0] data);
    res_t r;
    r = '0;
    r.packet_valid = 1'b1;
    r.packet_kind = kind;
    r.packet_cv = cv;
    r.packet_bit = bitn;
    r.packet_bit_value = bval;
    r.packet_byte = data;
    return r;
  endfunction

  task automatic clear_sequencer();
    ack_inc = RST_ACK_INC;
    preamble_cfg = RST_PREAMBLE;
    repeats_cfg = RST_REPEATS;
    trailing_cfg = RST_TRAILING;
    job = JOB_OFF;
    job_status = ST_IDLE;
    preamble_left = '0;
    writes_left = '0;
    bit_writes_left = '0;
    trailing_left = '0;
    verifies_left = '0;
    current_bit = '0;
    trial = 1'b1;
    single_target = BIT_NONE;
    value_found = '0;
    threshold = '0;
    tgt_cv = CV_W'(1);
    tgt_bit = '0;
    tgt_bval = 1'b0;
    tgt_byte = '0;
  endtask

  task automatic load_threshold(input logic [15:0] long_ma);
    threshold = {1'b0, long_ma} + {1'b0, ack_inc};
  endtask

  task automatic power_down();
    if (job_status == ST_BUSY) job_status = ST_FAILED;
    job = JOB_OFF;
  endtask

  task automatic write_tick(input prog_item_t it, inout res_t r);
    logic ack;
    ack = ({1'b0, it.short_cur} >= threshold);
    if (preamble_left != 0) begin
      if (it.need) begin
        r = packet_slot(KIND_RESET, '0, '0, 1'b0, '0);
        preamble_left = preamble_left - 1'b1;
        if (preamble_left == 0) load_threshold(it.long_ma);
      end
    end else begin
      if (ack) begin
        writes_left = '0;
        bit_writes_left = '0;
        trailing_left = '0;
        job_status = ST_SUCCESS;
      end
      if (writes_left != 0) begin
        if (it.need) begin
          r = packet_slot(KIND_WRITE_BYTE, tgt_cv, '0, 1'b0, tgt_byte);
          writes_left = writes_left - 1'b1;
        end
      end else if (bit_writes_left != 0) begin
        if (it.need) begin
          r = packet_slot(KIND_WRITE_BIT, tgt_cv, tgt_bit, tgt_bval, '0);
          bit_writes_left = bit_writes_left - 1'b1;
        end
      end else if (trailing_left != 0) begin
        if (it.need) begin
          r = packet_slot(KIND_RESET, '0, '0, 1'b0, '0);
          trailing_left = trailing_left - 1'b1;
        end
      end else begin
        power_down();
      end
    end
  endtask

  task automatic read_tick(input prog_item_t it, inout res_t r);
    logic single;
    logic ack;
    single = (single_target < BIT_BYTE_VERIFY);
    ack = ({1'b0, it.short_cur} >= threshold);
    if (preamble_left != 0) begin
      if (it.need) begin
        r = packet_slot(KIND_RESET, '0, '0, 1'b0, '0);
        preamble_left = preamble_left - 1'b1;
        if (preamble_left == 0) begin
          load_threshold(it.long_ma);
          current_bit = single ? single_target : BIT_TOP;
          verifies_left = repeat_count(repeats_cfg);
        end
      end
    end else begin
      if (ack) begin
        if (single) begin
          value_found = {7'd0, trial};
          job_status = ST_SUCCESS;
          verifies_left = '0;
          trailing_left = '0;
        end else if (current_bit >= BIT_BYTE_VERIFY) begin
          job_status = ST_SUCCESS;
          verifies_left = '0;
          trailing_left = '0;
        end else begin
          value_found[current_bit[2:0]] = 1'b1;
        end
      end
      if (verifies_left != 0) begin
        if (it.need) begin
          if (current_bit >= BIT_BYTE_VERIFY)
            r = packet_slot(KIND_VERIFY_BYTE, tgt_cv, '0, 1'b0, value_found);
          else
            r = packet_slot(KIND_VERIFY_BIT, tgt_cv, current_bit[2:0], trial, '0);
          verifies_left = verifies_left - 1'b1;
          if (verifies_left == 0) trailing_left = repeat_count(trailing_cfg);
        end
      end else if (trailing_left != 0) begin
        if (it.need) begin
          r = packet_slot(KIND_RESET, '0, '0, 1'b0, '0);
          trailing_left = trailing_left - 1'b1;
        end
        if (trailing_left == 0) load_threshold(it.long_ma);
      end else if (single) begin
        if (!trial && job_status == ST_BUSY) begin
          trial = 1'b1;
          verifies_left = repeat_count(repeats_cfg);
        end else begin
          power_down();
        end
      end else if (current_bit >= BIT_BYTE_VERIFY) begin
        power_down();
      end else if (current_bit != 0) begin
        current_bit = current_bit - 1'b1;
        trial = 1'b1;
        verifies_left = repeat_count(repeats_cfg);
      end else begin
        current_bit = BIT_BYTE_VERIFY;
        verifies_left = repeat_count(repeats_cfg);
      end
    end
  endtask

  task automatic advance_sequencer(input prog_item_t it, output res_t r);
    r = '0;
    case (it.mode)
      MODE_WRITE_BYTE, MODE_WRITE_BIT, MODE_READ_BYTE, MODE_READ_BIT: begin
        if (it.cv == '0 || it.cv > CV_COUNT) begin
          job = JOB_OFF;
          job_status = ST_FAILED;
        end else begin
          job = (it.mode == MODE_WRITE_BYTE || it.mode == MODE_WRITE_BIT) ? JOB_WRITE : JOB_READ;
          job_status = ST_BUSY;
          tgt_cv = it.cv;
          tgt_bit = it.bitn;
          tgt_bval = it.bval;
          tgt_byte = it.data;
          preamble_left = (preamble_cfg == 0) ? 5'd1 : preamble_cfg;
          writes_left = (it.mode == MODE_WRITE_BYTE) ? repeat_count(repeats_cfg) : 3'd0;
          bit_writes_left = (it.mode == MODE_WRITE_BIT) ? repeat_count(repeats_cfg) : 3'd0;
          trailing_left = (job == JOB_WRITE) ? repeat_count(trailing_cfg) : 3'd0;
          verifies_left = '0;
          current_bit = '0;
          value_found = '0;
          single_target = (it.mode == MODE_READ_BIT) ? {1'b0, it.bitn} : BIT_NONE;
          trial = (it.mode != MODE_READ_BIT);
        end
      end
      MODE_POWER_OFF: power_down();
      default: begin
        if (job == JOB_WRITE) write_tick(it, r);
        else if (job == JOB_READ) read_tick(it, r);
      end
    endcase
    r.status = job_status;
    r.read_value = value_found;
    r.track_enabled = (job != JOB_OFF);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fault_count = fault_count + 1;
    end
  endtask

  always @(posedge clk) begin
    prog_item_t it;
    res_t want;
    if (!rst_n) begin
      clear_sequencer();
      slots_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ACK_INC:  ack_inc = pwdata[15:0];
          REG_PREAMBLE: preamble_cfg = pwdata[4:0];
          REG_REPEATS:  repeats_cfg = pwdata[2:0];
          REG_TRAILING: trailing_cfg = pwdata[2:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (slots_due.size() == 0) begin
          $error("result item with no prediction waiting");
          fault_count = fault_count + 1;
        end else begin
          want = slots_due.pop_front();
          compare_field("packet_valid", 16'(want.packet_valid), 16'(out_packet_valid));
          compare_field("packet_kind", 16'(want.packet_kind), 16'(out_packet_kind));
          compare_field("packet_cv", 16'(want.packet_cv), 16'(out_packet_cv));
          compare_field("packet_bit", 16'(want.packet_bit), 16'(out_packet_bit));
          compare_field("packet_bit_value", 16'(want.packet_bit_value),
                        16'(out_packet_bit_value));
          compare_field("packet_byte", 16'(want.packet_byte), 16'(out_packet_byte));
          compare_field("status", 16'(want.status), 16'(out_status));
          compare_field("read_value", 16'(want.read_value), 16'(out_read_value));
          compare_field("track_enabled", 16'(want.track_enabled), 16'(out_track_enabled));
        end
      end
      if (in_valid && in_ready) begin
        it.mode = in_mode;
        it.cv = in_cv_number;
        it.bitn = in_bit_number;
        it.bval = in_bit_value;
        it.data = in_byte_value;
        it.need = in_need_packet;
        it.short_cur = in_short_current;
        it.long_ma = in_long_current;
        advance_sequencer(it, want);
        slots_due = {slots_due, want};
      end
    end
    slots_pending = slots_due.size();
    job_running = (job != JOB_OFF);
  end

endmodule

>>> dv/tb.sv
module tb;
  import dccsmp_pkg::*;

  // modes with no function of their own; the block treats them as ticks
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_mode;
  logic [CV_W-1:0]    in_cv_number;
  logic [2:0]         in_bit_number;
  logic               in_bit_value;
  logic [7:0]         in_byte_value;
  logic               in_need_packet;
  logic [15:0]        in_short_current;
  logic [15:0]        in_long_current;
  logic               out_valid;
  logic               out_ready;
  logic               out_packet_valid;
  logic [2:0]         out_packet_kind;
  logic [CV_W-1:0]    out_packet_cv;
  logic [2:0]         out_packet_bit;
  logic               out_packet_bit_value;
  logic [7:0]         out_packet_byte;
  logic [1:0]         out_status;
  logic [7:0]         out_read_value;
  logic               out_track_enabled;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int unsigned        fault_count;
  int unsigned        slots_pending;
  bit                 job_running;

  int          burst_left;
  bit          gap_on;
  int          items_left;
  logic [15:0] ack_inc_now;

  dcc_service_mode_programmer uut (.*);
  dccsmp_sequence_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int seg;
    int pct;
    out_ready = 1'b0;
    forever begin
      seg = $urandom_range(10, 120);
      case ($urandom_range(0, 3))
        0: pct = 100;
        1: pct = 75;
        2: pct = 40;
        default: pct = 10;
      endcase
      repeat (seg) begin
        @(negedge clk);
        out_ready <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // called and returns at a falling edge
  task automatic put_item(input logic [2:0] mode, input logic [CV_W-1:0] cv,
                          input logic [2:0] bitn, input logic bval, input logic [7:0] data,
                          input logic need, input logic [15:0] short_cur,
                          input logic [15:0] long_ma);
    int gap;
    if (gap_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_cv_number <= cv;
    in_bit_number <= bitn;
    in_bit_value <= bval;
    in_byte_value <= data;
    in_need_packet <= need;
    in_short_current <= short_cur;
    in_long_current <= long_ma;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (items_left > 0) items_left--;
  endtask

  task automatic tick(input logic need, input logic [15:0] short_cur,
                      input logic [15:0] long_ma);
    put_item(MODE_TICK, 11'd1, 3'd0, 1'b0, 8'd0, need, short_cur, long_ma);
  endtask

  // leaves psel high; the caller closes the last transfer
  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [15:0] ack, input logic [4:0] pre,
                              input logic [2:0] rep, input logic [2:0] trl);
    in_valid <= 1'b0;
    while (slots_pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    write_reg(REG_ACK_INC, {16'd0, ack});
    write_reg(REG_PREAMBLE, {27'd0, pre});
    write_reg(REG_REPEATS, {29'd0, rep});
    write_reg(REG_TRAILING, {29'd0, trl});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    ack_inc_now = ack;
  endtask

  function automatic logic [CV_W-1:0] random_cv();
    int p;
    p = $urandom_range(0, 99);
    if (p < 4) return '0;
    if (p < 8) return CV_W'($urandom_range(CV_COUNT + 1, {CV_W{1'b1}}));
    if (p < 12) return CV_COUNT;
    if (p < 16) return CV_W'(1);
    return CV_W'($urandom_range(1, CV_COUNT));
  endfunction

  function automatic logic [2:0] random_start();
    case ($urandom_range(0, 3))
      0: return MODE_WRITE_BYTE;
      1: return MODE_WRITE_BIT;
      2: return MODE_READ_BYTE;
      default: return MODE_READ_BIT;
    endcase
  endfunction

  // one start followed by ticks until the job ends or an item limit is hit, with some noise mixed in
  task automatic run_job();
    logic [2:0]  mode;
    logic [15:0] base_long;
    logic [15:0] short_cur;
    logic [15:0] long_ma;
    logic [16:0] thr;
    logic [16:0] lim;
    int          need_pct;
    int          ack_pct;
    int          n;
    int          pick;
    case ($urandom_range(0, 3))
      0: base_long = 16'd0;
      1: base_long = 16'($urandom);
      default: base_long = 16'($urandom_range(0, 2000));
    endcase
    case ($urandom_range(0, 2))
      0: need_pct = 100;
      1: need_pct = 85;
      default: need_pct = 50;
    endcase
    case ($urandom_range(0, 2))
      0: ack_pct = 2;
      1: ack_pct = 8;
      default: ack_pct = 20;
    endcase
    put_item(random_start(), random_cv(), 3'($urandom), 1'($urandom), 8'($urandom),
             1'($urandom), 16'($urandom), 16'($urandom));
    n = 0;
    while (job_running && n < 600 && items_left > 0) begin
      thr = {1'b0, base_long} + {1'b0, ack_inc_now};
      long_ma = ($urandom_range(0, 9) == 0) ? 16'($urandom) : base_long;
      if ($urandom_range(0, 99) < ack_pct) begin
        if (thr > 17'h0FFFF) short_cur = 16'hFFFF;
        else if ($urandom_range(0, 1) == 0) short_cur = thr[15:0];
        else short_cur = 16'($urandom_range(thr, 65535));
      end else if (thr == 0) begin
        short_cur = 16'd0;
      end else begin
        lim = (thr > 17'h10000) ? 17'h0FFFF : thr - 17'd1;
        short_cur = ($urandom_range(0, 3) == 0) ? lim[15:0] : 16'($urandom_range(0, lim));
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) mode = MODE_POWER_OFF;
      else if (pick < 3) mode = random_start();
      else if (pick < 5) mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE_A : MODE_SPARE_B;
      else mode = MODE_TICK;
      put_item(mode, random_cv(), 3'($urandom), 1'($urandom), 8'($urandom),
               ($urandom_range(0, 99) < need_pct), short_cur, long_ma);
      n++;
    end
    repeat ($urandom_range(0, 2))
      if (items_left > 0) tick(1'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int ph;
    int w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_TICK;
    in_cv_number = '0;
    in_bit_number = '0;
    in_bit_value = 1'b0;
    in_byte_value = '0;
    in_need_packet = 1'b0;
    in_short_current = '0;
    in_long_current = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    burst_left = 0;
    gap_on = 1'b0;
    items_left = 0;
    ack_inc_now = RST_ACK_INC;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    program_regs(16'd100, 5'd1, 3'd1, 3'd1);
    tick(1'b1, 16'd0, 16'd0);
    put_item(MODE_SPARE_A, 11'd1, 3'd0, 1'b0, 8'd0, 1'b1, 16'd0, 16'd0);
    put_item(MODE_WRITE_BYTE, 11'd0, 3'd0, 1'b0, 8'd0, 1'b1, 16'd0, 16'd0);
    put_item(MODE_READ_BYTE, {CV_W{1'b1}}, 3'd7, 1'b1, 8'hFF, 1'b1, 16'd0, 16'd0);
    put_item(MODE_WRITE_BYTE, CV_COUNT, 3'd7, 1'b1, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF);
    tick(1'b0, 16'd0, 16'd0);
    tick(1'b1, 16'd0, 16'd0);
    tick(1'b1, 16'd99, 16'd0);
    tick(1'b1, 16'd100, 16'd0);
    put_item(MODE_WRITE_BIT, 11'd1, 3'd7, 1'b1, 8'h00, 1'b0, 16'd0, 16'd0);
    tick(1'b1, 16'd0, 16'hFFFF);
    tick(1'b1, 16'hFFFF, 16'd0);
    tick(1'b1, 16'hFFFF, 16'd0);
    tick(1'b1, 16'hFFFF, 16'd0);
    put_item(MODE_READ_BIT, 11'd5, 3'd3, 1'b0, 8'h00, 1'b1, 16'd0, 16'd0);
    tick(1'b1, 16'd0, 16'd0);
    tick(1'b1, 16'd0, 16'd0);
    tick(1'b1, 16'd0, 16'd0);
    tick(1'b1, 16'd0, 16'd0);
    tick(1'b1, 16'd200, 16'd0);
    put_item(MODE_READ_BYTE, 11'd3, 3'd0, 1'b0, 8'h00, 1'b1, 16'd0, 16'd0);
    put_item(MODE_WRITE_BYTE, 11'd9, 3'd0, 1'b0, 8'hA5, 1'b1, 16'd0, 16'd0);
    put_item(MODE_POWER_OFF, 11'd1, 3'd0, 1'b0, 8'h00, 1'b1, 16'd0, 16'd0);
    put_item(MODE_POWER_OFF, 11'd1, 3'd0, 1'b0, 8'h00, 1'b1, 16'd0, 16'd0);
    put_item(MODE_SPARE_B, 11'd1, 3'd0, 1'b0, 8'h00, 1'b1, 16'd0, 16'd0);

    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: program_regs(RST_ACK_INC, RST_PREAMBLE, RST_REPEATS, RST_TRAILING);
        1: program_regs(16'd0, 5'd1, 3'd1, 3'd1);
        2: program_regs(16'hFFFF, 5'd31, 3'd7, 3'd7);
        3: program_regs(16'd0, 5'd0, 3'd0, 3'd0);
        default:
          program_regs(($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 400)) : 16'($urandom),
                       5'($urandom_range(0, 10)), 3'($urandom), 3'($urandom));
      endcase
      gap_on = ($urandom_range(0, 9) < 7);
      items_left = 200;
      while (items_left > 0) run_job();
    end

    in_valid <= 1'b0;
    for (w = 0; w < 20000 && slots_pending != 0; w++) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fault_count == 0 && slots_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/dccsmp_pkg.sv
hw/rtl/dccsmp_regs.sv
hw/rtl/dcc_service_mode_programmer.sv
dv/dccsmp_sequence_checker.sv
dv/tb.sv
